// ===== src/biq_pkg.sv =====
// biq_pkg: shared types and constants for the biquad iir filter
// used by biq_mac_lane and biquad_iir_filter_top, no dependencies
`default_nettype none

package biq_pkg;

  // fixed field widths
  localparam int COEF_WIDTH      = 18;
  localparam int NUM_COEFS       = 5;
  localparam int CFG_INDEX_WIDTH = 3;

  // parameter defaults
  localparam int DEF_SAMPLE_WIDTH   = 16;
  localparam int DEF_COEF_FRAC_BITS = 14;

  // coefficient reset values
  localparam logic [COEF_WIDTH-1:0] B0_RESET = COEF_WIDTH'(16384);

  // register index map
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } biq_coef_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULX,
    S_ROUND,
    S_MULY,
    S_DONE
  } biq_state_t;

  // per-lane control from the sequencer
  typedef struct packed {
    logic load_acc;
    logic load_coef;
    logic step;
    logic mbit;
    logic sub;
  } biq_lane_ctl_t;

endpackage

`default_nettype wire

// ===== src/biquad_iir_filter_top.sv =====
// biquad_iir_filter_top: second-order iir section, transposed direct form ii
// depends on biq_pkg and biq_mac_lane
`default_nettype none

// one signed sample in, one rounded and saturated sample out. in each beat
// three bit-serial multiply-accumulate lanes walk the input sample one bit a
// cycle to form b0*x+delay_one, b1*x+delay_two and b2*x, a round step rounds
// and saturates the output, the same lanes then walk the output one bit a
// cycle to subtract a1*y and a2*y, and a done step saturates both delay
// accumulators and loads the output register. the output register holds a
// finished result while the next input beat is taken; if it is still full
// when the next result is ready the sequencer waits. coefficients are signed
// q3.14 (COEF_FRAC_BITS fraction bits); the user must write them through the
// cfg port only while the filter is idle, the block does not enforce this;
// writes to unused indexes are dropped. out_clipped flags a saturation of the
// output or of either delay accumulator for that sample.
module biquad_iir_filter_top #(
  parameter int SAMPLE_WIDTH   = biq_pkg::DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = biq_pkg::DEF_COEF_FRAC_BITS
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // input channel
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [SAMPLE_WIDTH-1:0]              in_sample_in,
  // result channel
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [SAMPLE_WIDTH-1:0]              out_sample_out,
  output logic                                 out_clipped,
  // coefficient write port
  input  wire                                  cfg_we,
  input  wire  [biq_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire  [biq_pkg::COEF_WIDTH-1:0]       cfg_data
);

  localparam int CW     = biq_pkg::COEF_WIDTH;
  // delay accumulators: sample width plus fraction bits plus headroom
  localparam int ACC_W  = SAMPLE_WIDTH + COEF_FRAC_BITS + 10;
  // exact sum width before delay saturation
  localparam int SUM_W  = ACC_W + 2;
  // coefficient shifted by up to SAMPLE_WIDTH-1 places
  localparam int SH_W   = CW + SAMPLE_WIDTH;
  localparam int CNT_W  = $clog2(SAMPLE_WIDTH);
  localparam int RHI_W  = SUM_W - COEF_FRAC_BITS - SAMPLE_WIDTH + 1;
  localparam int DHI_W  = SUM_W - ACC_W + 1;

  // coefficient registers
  logic [CW-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;

  // sequencer
  biq_pkg::biq_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                last_bit;

  // serial operand shifters and per-sample results
  logic [SAMPLE_WIDTH-1:0] x_sh_r, y_sh_r, y_r;
  logic                    clip_r;

  // filter state
  logic [ACC_W-1:0] d1_r, d2_r;

  // output register
  logic                    out_valid_r;
  logic [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                    out_clipped_r;

  // lane hookup
  biq_pkg::biq_lane_ctl_t ctl0, ctl1, ctl2;
  logic [CW-1:0]    coef1, coef2;
  logic [SUM_W-1:0] init0, init1, acc0, acc1, acc2;

  // output rounding
  logic [SUM_W-1:0]        rnd_sum;
  logic [RHI_W-1:0]        rnd_hi;
  logic                    rnd_ovf;
  logic [SAMPLE_WIDTH-1:0] y_val;

  // delay saturation
  logic [DHI_W-1:0] n1_hi, n2_hi;
  logic             n1_ovf, n2_ovf;
  logic [ACC_W-1:0] n1_sat, n2_sat;

  logic out_free;

  assign out_free = !out_valid_r || out_ready;
  assign last_bit = (cnt_r == CNT_W'(SAMPLE_WIDTH - 1));
  assign in_ready = (state_r == biq_pkg::S_IDLE);

  // coefficient writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= biq_pkg::B0_RESET;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        biq_pkg::COEF_B0: b0_r <= cfg_data;
        biq_pkg::COEF_B1: b1_r <= cfg_data;
        biq_pkg::COEF_B2: b2_r <= cfg_data;
        biq_pkg::COEF_A1: a1_r <= cfg_data;
        biq_pkg::COEF_A2: a2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // lane operands: feedforward coefficients first, feedback ones reloaded
  // in the round cycle
  assign coef1 = (state_r == biq_pkg::S_ROUND) ? a1_r : b1_r;
  assign coef2 = (state_r == biq_pkg::S_ROUND) ? a2_r : b2_r;
  assign init0 = {{(SUM_W-ACC_W){d1_r[ACC_W-1]}}, d1_r};
  assign init1 = {{(SUM_W-ACC_W){d2_r[ACC_W-1]}}, d2_r};

  biq_mac_lane #(.CW(CW), .SH_W(SH_W), .SUM_W(SUM_W)) u_lane0 (
    .clk (clk), .ctl (ctl0), .coef (b0_r), .init (init0), .acc (acc0)
  );

  biq_mac_lane #(.CW(CW), .SH_W(SH_W), .SUM_W(SUM_W)) u_lane1 (
    .clk (clk), .ctl (ctl1), .coef (coef1), .init (init1), .acc (acc1)
  );

  biq_mac_lane #(.CW(CW), .SH_W(SH_W), .SUM_W(SUM_W)) u_lane2 (
    .clk (clk), .ctl (ctl2), .coef (coef2), .init ('0), .acc (acc2)
  );

  // round half up, drop the fraction bits, saturate to the sample width
  always_comb begin
    rnd_sum = acc0 + (SUM_W'(1) << (COEF_FRAC_BITS - 1));
    rnd_hi  = rnd_sum[SUM_W-1:COEF_FRAC_BITS+SAMPLE_WIDTH-1];
    rnd_ovf = !((&rnd_hi) || !(|rnd_hi));
    if (rnd_ovf) begin
      y_val = rnd_sum[SUM_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                               : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end else begin
      y_val = rnd_sum[COEF_FRAC_BITS+SAMPLE_WIDTH-1:COEF_FRAC_BITS];
    end
  end

  // delay accumulator saturation
  always_comb begin
    n1_hi  = acc1[SUM_W-1:ACC_W-1];
    n2_hi  = acc2[SUM_W-1:ACC_W-1];
    n1_ovf = !((&n1_hi) || !(|n1_hi));
    n2_ovf = !((&n2_hi) || !(|n2_hi));
    if (n1_ovf) begin
      n1_sat = acc1[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      n1_sat = acc1[ACC_W-1:0];
    end
    if (n2_ovf) begin
      n2_sat = acc2[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      n2_sat = acc2[ACC_W-1:0];
    end
  end

  // sequencer: next state and lane control
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl0      = '0;
    ctl1      = '0;
    ctl2      = '0;
    case (state_r)
      biq_pkg::S_IDLE: begin
        if (in_valid) begin
          // load b0/b1/b2 and seed the first two sums with the delays
          ctl0.load_acc  = 1'b1;
          ctl0.load_coef = 1'b1;
          ctl1.load_acc  = 1'b1;
          ctl1.load_coef = 1'b1;
          ctl2.load_acc  = 1'b1;
          ctl2.load_coef = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = biq_pkg::S_MULX;
        end
      end
      biq_pkg::S_MULX: begin
        // sample bits lsb first, sign bit carries negative weight
        ctl0.step = 1'b1;
        ctl0.mbit = x_sh_r[0];
        ctl0.sub  = last_bit;
        ctl1      = ctl0;
        ctl2      = ctl0;
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (last_bit) begin
          state_nxt = biq_pkg::S_ROUND;
        end
      end
      biq_pkg::S_ROUND: begin
        ctl1.load_coef = 1'b1;
        ctl2.load_coef = 1'b1;
        cnt_nxt        = '0;
        state_nxt      = biq_pkg::S_MULY;
      end
      biq_pkg::S_MULY: begin
        // feedback terms are subtracted, so the sign sense flips
        ctl1.step = 1'b1;
        ctl1.mbit = y_sh_r[0];
        ctl1.sub  = !last_bit;
        ctl2      = ctl1;
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (last_bit) begin
          state_nxt = biq_pkg::S_DONE;
        end
      end
      biq_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = biq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = biq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= biq_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // operand shifters and per-sample payload
  always_ff @(posedge clk) begin
    case (state_r)
      biq_pkg::S_IDLE: begin
        if (in_valid) begin
          x_sh_r <= in_sample_in;
        end
      end
      biq_pkg::S_MULX: begin
        x_sh_r <= x_sh_r >> 1;
      end
      biq_pkg::S_ROUND: begin
        y_r    <= y_val;
        y_sh_r <= y_val;
        clip_r <= rnd_ovf;
      end
      biq_pkg::S_MULY: begin
        y_sh_r <= y_sh_r >> 1;
      end
      default: ;
    endcase
  end

  // filter state, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= '0;
      d2_r <= '0;
    end else if (state_r == biq_pkg::S_DONE && out_free) begin
      d1_r <= n1_sat;
      d2_r <= n2_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == biq_pkg::S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == biq_pkg::S_DONE && out_free) begin
      out_sample_r  <= y_r;
      out_clipped_r <= clip_r || n1_ovf || n2_ovf;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;

endmodule

`default_nettype wire

// ===== src/biq_mac_lane.sv =====
// biq_mac_lane: bit-serial multiply-accumulate lane, one multiplier bit per cycle
// depends on biq_pkg (lane control struct)
`default_nettype none

module biq_mac_lane #(
  parameter int CW    = biq_pkg::COEF_WIDTH,
  parameter int SH_W  = biq_pkg::COEF_WIDTH + biq_pkg::DEF_SAMPLE_WIDTH,
  parameter int SUM_W = 42
) (
  input  wire                      clk,
  input  wire biq_pkg::biq_lane_ctl_t ctl,
  input  wire  [CW-1:0]            coef,
  input  wire  [SUM_W-1:0]         init,
  output logic [SUM_W-1:0]         acc
);

  logic [SH_W-1:0]  sh_r, sh_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic [SUM_W-1:0] addend;

  always_comb begin
    addend = {{(SUM_W-SH_W){sh_r[SH_W-1]}}, sh_r} ^ {SUM_W{ctl.sub}};
    sh_nxt  = sh_r;
    acc_nxt = acc_r;
    if (ctl.load_coef) begin
      sh_nxt = {{(SH_W-CW){coef[CW-1]}}, coef};
    end else if (ctl.step) begin
      sh_nxt = {sh_r[SH_W-2:0], 1'b0};
    end
    if (ctl.load_acc) begin
      acc_nxt = init;
    end else if (ctl.step && ctl.mbit) begin
      // negation as invert plus carry-in
      acc_nxt = acc_r + addend + SUM_W'(ctl.sub);
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// ===== verif/biquad_iir_filter_top_test.sv =====
// biquad_iir_filter_top_test: self-checking testbench for the biquad iir filter
// drives samples and coefficient writes, predicts each filtered beat in the bench
// depends on biq_pkg and biquad_iir_filter_top
`default_nettype none

module biquad_iir_filter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COEF_WIDTH      = biq_pkg::COEF_WIDTH;
  localparam int NUM_COEFS       = biq_pkg::NUM_COEFS;
  localparam int CFG_INDEX_WIDTH = biq_pkg::CFG_INDEX_WIDTH;

  localparam int SW            = biq_pkg::DEF_SAMPLE_WIDTH;
  localparam int FRAC          = biq_pkg::DEF_COEF_FRAC_BITS;
  localparam int DELAY_WIDTH   = 40;
  // one beat walks the sample and then the output bit-serially
  localparam int BEAT_CYCLES   = 2 * SW + 3;
  localparam int SETTLE_CYCLES = BEAT_CYCLES + 10;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 10;

  localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};
  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = biq_pkg::B0_RESET;
  localparam logic signed [COEF_WIDTH-1:0] COEF_HALF = biq_pkg::B0_RESET >>> 1;
  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

  // one filtered beat as seen on the result channel
  typedef struct packed {
    logic [SW-1:0] sample;
    logic          clipped;
  } filt_beat_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [SW-1:0]              in_sample_in;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [SW-1:0]              out_sample_out;
  logic                       out_clipped;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [COEF_WIDTH-1:0]      cfg_data;

  // bench copy of the filter: coefficients and the two delay accumulators
  logic signed [COEF_WIDTH-1:0]  coef_bank [NUM_COEFS];
  logic signed [DELAY_WIDTH-1:0] delay_one_q;
  logic signed [DELAY_WIDTH-1:0] delay_two_q;

  filt_beat_t          expected_beats[$];
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  error_count = 0;
  int                  cycle_count = 0;
  logic signed [SW-1:0] last_sample;

  biquad_iir_filter_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog, also catches results that never arrive
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // clamp to a signed w-bit range and note whether it bit
  function automatic longint clamp_to(input longint v, input int w, inout bit hit);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // transposed direct form ii step: output from b0*x plus the first delay,
  // then both delays updated from x and the rounded, clamped output
  function automatic filt_beat_t filter_sample(input logic signed [SW-1:0] x);
    longint     acc;
    longint     y;
    longint     n1;
    longint     n2;
    bit         hit;
    filt_beat_t r;
    hit = 1'b0;
    acc = longint'(coef_bank[biq_pkg::COEF_B0]) * longint'(x) + longint'(delay_one_q);
    // round half up, then floor through the arithmetic shift
    y   = clamp_to((acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC, SW, hit);
    n1  = longint'(coef_bank[biq_pkg::COEF_B1]) * longint'(x)
          - longint'(coef_bank[biq_pkg::COEF_A1]) * y + longint'(delay_two_q);
    n2  = longint'(coef_bank[biq_pkg::COEF_B2]) * longint'(x)
          - longint'(coef_bank[biq_pkg::COEF_A2]) * y;
    delay_one_q = DELAY_WIDTH'(clamp_to(n1, DELAY_WIDTH, hit));
    delay_two_q = DELAY_WIDTH'(clamp_to(n2, DELAY_WIDTH, hit));
    r.sample  = SW'(y);
    r.clipped = hit;
    return r;
  endfunction

  task automatic log_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
  endtask

  // result side: check each accepted beat against the oldest prediction,
  // then pick the ready level for the next edge
  always @(posedge clk) begin : result_check
    filt_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        log_error($sformatf("unexpected beat: sample_out %0d clipped %0b",
                            $signed(out_sample_out), out_clipped));
      end else begin
        want = expected_beats.pop_front();
        if (want.sample !== out_sample_out || want.clipped !== out_clipped) begin
          log_error($sformatf("bad beat: sample_out exp %0d got %0d, clipped exp %0b got %0b",
                              $signed(want.sample), $signed(out_sample_out),
                              want.clipped, out_clipped));
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // offer one sample, hold it until taken, then predict its beat
  task automatic send_sample(input logic signed [SW-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_beats.push_back(filter_sample(x));
  endtask

  // drop valid, let every predicted beat come back, then let the sequencer settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [COEF_WIDTH-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    // unused indexes are dropped by the block
    if (idx < NUM_COEFS) coef_bank[idx] = data;
    @(posedge clk);
  endtask

  task automatic load_coefs(input logic signed [COEF_WIDTH-1:0] b0, b1, b2, a1, a2);
    wait_idle();
    write_reg(biq_pkg::COEF_B0, b0);
    write_reg(biq_pkg::COEF_B1, b1);
    write_reg(biq_pkg::COEF_B2, b2);
    write_reg(biq_pkg::COEF_A1, a1);
    write_reg(biq_pkg::COEF_A2, a2);
  endtask

  // mostly full-range noise, some small values, rail hits and held steps
  function automatic logic signed [SW-1:0] next_sample();
    logic signed [SW-1:0] s;
    case ($urandom_range(7))
      0, 1, 2, 3: s = SW'($urandom);
      4, 5:       s = SW'($urandom_range(512) - 256);
      6:          s = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      default:    s = last_sample;
    endcase
    last_sample = s;
    return s;
  endfunction

  // pass-through at the reset coefficients, rails and alternating patterns
  task automatic test_reset_passthrough();
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SW'(1));
    send_sample(-SW'(1));
    send_sample({(SW/2){2'b01}});
    send_sample({(SW/2){2'b10}});
  endtask

  // gain of nearly eight, both signs, drives the output into either rail
  task automatic test_output_saturation();
    load_coefs(COEF_MAX, '0, '0, '0, '0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SW'(1));
    load_coefs(COEF_MIN, '0, '0, '0, '0);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
  endtask

  // half-way cases of the output rounding, with no delayed terms
  task automatic test_rounding();
    load_coefs(COEF_HALF, '0, '0, '0, '0);
    send_sample(SW'(1));
    send_sample(-SW'(1));
    send_sample(SW'(3));
    send_sample(-SW'(3));
  endtask

  // b0 at one, every other coefficient at a rail: feedback at full strength, delays near their
  // largest reachable values (40 bits cannot overflow at this sample width)
  task automatic test_feedback_extremes();
    load_coefs(COEF_ONE, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample('0);
  endtask

  // writes to unused indexes must leave the coefficients alone
  task automatic test_unused_index();
    int k;
    load_coefs(COEF_WIDTH'(12345), -COEF_WIDTH'(5000), '0, '0, '0);
    for (k = 0; k < 3; k++) begin
      wait_idle();
      write_reg(CFG_INDEX_WIDTH'(NUM_COEFS + k), COEF_WIDTH'($urandom));
      send_sample(next_sample());
    end
  endtask

  // coefficient set for one random phase
  task automatic pick_coefs(input int kind);
    logic signed [COEF_WIDTH-1:0] c [NUM_COEFS];
    int a2v;
    int span;
    int gain;
    int k;
    case (kind)
      0, 3: begin
        // stable section: |a2| < 1 and |a1| < 1 + a2
        a2v  = $urandom_range(15000);
        span = 16384 + a2v - 600;
        gain = (kind == 0) ? 3000 : 60000;
        for (k = 0; k < 3; k++) c[k] = COEF_WIDTH'(int'($urandom_range(2 * gain)) - gain);
        c[biq_pkg::COEF_A1] = COEF_WIDTH'(int'($urandom_range(2 * span)) - span);
        c[biq_pkg::COEF_A2] = COEF_WIDTH'(a2v);
      end
      1: begin
        for (k = 0; k < NUM_COEFS; k++) c[k] = COEF_WIDTH'($urandom);
      end
      2: begin
        for (k = 0; k < NUM_COEFS; k++) begin
          case ($urandom_range(3))
            0:       c[k] = COEF_MAX;
            1:       c[k] = COEF_MIN;
            2:       c[k] = COEF_ONE;
            default: c[k] = '0;
          endcase
        end
      end
      default: begin
        c[biq_pkg::COEF_B0] = COEF_ONE;
        for (k = 1; k < NUM_COEFS; k++) c[k] = COEF_WIDTH'(int'($urandom_range(4000)) - 2000);
      end
    endcase
    load_coefs(c[biq_pkg::COEF_B0], c[biq_pkg::COEF_B1], c[biq_pkg::COEF_B2],
               c[biq_pkg::COEF_A1], c[biq_pkg::COEF_A2]);
  endtask

  // three handshake profiles, five coefficient sets each, thirty samples per set
  task automatic test_random_filters();
    int profile;
    int set_no;
    for (profile = 0; profile < 3; profile++) begin
      case (profile)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (set_no = 0; set_no < 5; set_no++) begin
        pick_coefs(set_no);
        repeat (30) send_sample(next_sample());
      end
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_sample_in <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= biq_pkg::COEF_B0;
    cfg_data     <= '0;
    // directed part runs under the first handshake profile
    send_idle_pct = 25;
    recv_idle_pct = 84;
    last_sample   = '0;
    // bench state matches the block after reset
    coef_bank[biq_pkg::COEF_B0] = COEF_ONE;
    coef_bank[biq_pkg::COEF_B1] = '0;
    coef_bank[biq_pkg::COEF_B2] = '0;
    coef_bank[biq_pkg::COEF_A1] = '0;
    coef_bank[biq_pkg::COEF_A2] = '0;
    delay_one_q = '0;
    delay_two_q = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part first, then the random phases
    test_reset_passthrough();
    test_output_saturation();
    test_rounding();
    test_feedback_extremes();
    test_unused_index();
    test_random_filters();

    wait_idle();
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== biquad_iir_filter_top.f =====
src/biq_pkg.sv
src/biq_mac_lane.sv
src/biquad_iir_filter_top.sv
verif/biquad_iir_filter_top_test.sv
